// File: rtl/rbsp_pkg.sv
// Shared types and constants for the rational Bezier sphere patch evaluator.
// No dependencies; every other file uses this package.
package rbsp_pkg;

	localparam int FIELD_W = 16;
	localparam int INV_W = 30;
	// 1/sqrt2 with 30 fraction bits
	localparam logic [INV_W-1:0] INV_SQRT2_Q30 = 30'd759250125;

	// control point selection masks, bit index = u_index * 3 + v_index
	localparam logic [8:0] MASK_X = 9'b000110110;
	localparam logic [8:0] MASK_Y = 9'b110110000;
	localparam logic [8:0] MASK_Z = 9'b011011011;

	// pipeline control handed to the divider
	typedef struct packed {
		logic ce;
		logic valid;
	} rbsp_ctl_t;

endpackage

// File: rtl/rbsp_if.sv
// Valid/ready channel interfaces for parameter pairs and surface points.
// Depends on rbsp_pkg for the field width.
interface rbsp_req_if;
	logic valid;
	logic ready;
	logic [rbsp_pkg::FIELD_W-1:0] param_u;
	logic [rbsp_pkg::FIELD_W-1:0] param_v;
	modport source(output valid, output param_u, output param_v, input ready);
	modport sink(input valid, input param_u, input param_v, output ready);
endinterface

interface rbsp_rsp_if;
	logic valid;
	logic ready;
	logic [rbsp_pkg::FIELD_W-1:0] pos_x;
	logic [rbsp_pkg::FIELD_W-1:0] pos_y;
	logic [rbsp_pkg::FIELD_W-1:0] pos_z;
	modport source(output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// File: rtl/rational_bezier_sphere_patch_eval.sv
// Rational biquadratic Bezier patch evaluator for one octant of the unit sphere.
// Takes (u,v) in unsigned Q1.FRAC_BITS, returns the surface point clamped to 0..1.
// Channels: req (sink) carries param_u/param_v, rsp (source) carries pos_x/y/z;
// an item moves on a transfer, valid and ready high at a rising edge of clk.
// Throughput: one item per cycle while rsp takes its results, no dependence between items.
// Pipeline: 6 front stages (clamp, Bernstein products, rounding, 1/sqrt2 scale,
// tensor products, term sums) plus FRAC_BITS+2 divider stages (one dividend
// setup stage, one quotient bit per stage) lie between transfer in and rsp.
// The last divider stage is the output register; rsp.valid comes from it.
// Stall: while rsp holds a result that is not taken the whole pipeline holds
// and req.ready drops; nothing is lost or repeated, bubbles keep their place.
// Reset (arst_n low, asynchronous) clears every stage valid bit; payload
// registers keep whatever they hold. No configuration and no state between items.
// Depends on rbsp_pkg, rbsp_if and rbsp_div.
module rational_bezier_sphere_patch_eval #(
	parameter int FRAC_BITS = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	rbsp_req_if.sink   req,
	rbsp_rsp_if.source rsp
);
	import rbsp_pkg::*;

	localparam int TW = FRAC_BITS + 1;
	localparam int PW = 2 * FRAC_BITS + 2;
	localparam int SW = FRAC_BITS + 4;
	localparam int CW = (TW > FIELD_W) ? TW : FIELD_W;
	localparam int MW = TW + INV_W;
	localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;
	localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
	localparam logic [MW-1:0] HALF_M = MW'(1) << (INV_W - 1);

	logic ce;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [TW-1:0] t_s1 [2];
	logic [TW-1:0] s_s1 [2];
	logic [PW-1:0] ss_s2 [2];
	logic [PW-1:0] ts_s2 [2];
	logic [PW-1:0] tt_s2 [2];
	logic [TW-1:0] f0_s3 [2];
	logic [TW-1:0] b1_s3 [2];
	logic [TW-1:0] f2_s3 [2];
	logic [TW-1:0] f_s4 [2][3];
	logic [PW-1:0] p_s5 [9];
	logic [SW-1:0] sx_s6, sy_s6, sz_s6, sw_s6;

	logic [FIELD_W-1:0] raw [2];
	logic [SW-1:0]      term [9];
	logic [SW-1:0]      sx_c, sy_c, sz_c, sw_c;
	logic [SW-1:0]      num [3];
	rbsp_ctl_t          div_ctl;
	logic               div_valid;
	logic [TW-1:0]      quot [3];
	logic               zero_den;
	logic [TW-1:0]      qc [3];

	// hold everything while the output register is full and not taken
	assign ce = !rsp.valid || rsp.ready;
	assign req.ready = ce;

	assign raw[0] = req.param_u;
	assign raw[1] = req.param_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (ce) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int a = 0; a < 2; a++) begin
				// saturate the parameter at 1.0
				if (CW'(raw[a]) > CW'(ONE)) begin
					t_s1[a] <= ONE;
					s_s1[a] <= '0;
				end else begin
					t_s1[a] <= TW'(raw[a]);
					s_s1[a] <= ONE - TW'(raw[a]);
				end
				ss_s2[a] <= PW'(s_s1[a]) * PW'(s_s1[a]);
				ts_s2[a] <= PW'(t_s1[a]) * PW'(s_s1[a]);
				tt_s2[a] <= PW'(t_s1[a]) * PW'(t_s1[a]);
				f0_s3[a] <= TW'((ss_s2[a] + HALF_P) >> FRAC_BITS);
				b1_s3[a] <= TW'(((ts_s2[a] << 1) + HALF_P) >> FRAC_BITS);
				f2_s3[a] <= TW'((tt_s2[a] + HALF_P) >> FRAC_BITS);
				f_s4[a][0] <= f0_s3[a];
				f_s4[a][1] <= TW'((MW'(b1_s3[a]) * MW'(INV_SQRT2_Q30) + HALF_M) >> INV_W);
				f_s4[a][2] <= f2_s3[a];
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s5[i*3+j] <= PW'(f_s4[0][i]) * PW'(f_s4[1][j]);
				end
			end
			sx_s6 <= sx_c;
			sy_s6 <= sy_c;
			sz_s6 <= sz_c;
			sw_s6 <= sw_c;
		end
	end

	// round each tensor term, then gather the masked sums
	always_comb begin
		sx_c = '0;
		sy_c = '0;
		sz_c = '0;
		sw_c = '0;
		for (int n = 0; n < 9; n++) begin
			term[n] = SW'((p_s5[n] + HALF_P) >> FRAC_BITS);
			sw_c = sw_c + term[n];
			if (MASK_X[n]) sx_c = sx_c + term[n];
			if (MASK_Y[n]) sy_c = sy_c + term[n];
			if (MASK_Z[n]) sz_c = sz_c + term[n];
		end
	end

	assign num[0] = sx_s6;
	assign num[1] = sy_s6;
	assign num[2] = sz_s6;
	assign div_ctl.ce = ce;
	assign div_ctl.valid = v_s6;

	rbsp_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.num      (num),
		.den      (sw_s6),
		.valid    (div_valid),
		.quot     (quot),
		.zero_den (zero_den)
	);

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (zero_den) qc[l] = '0;
			else if (quot[l] > ONE) qc[l] = ONE;
			else qc[l] = quot[l];
		end
	end

	assign rsp.valid = div_valid;
	assign rsp.pos_x = FIELD_W'(qc[0]);
	assign rsp.pos_y = FIELD_W'(qc[1]);
	assign rsp.pos_z = FIELD_W'(qc[2]);

	localparam logic [FIELD_W:0] ONE_CHK = (FIELD_W+1)'(1) << FRAC_BITS;

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (FRAC_BITS > 15) ||
			(({1'b0, rsp.pos_x} <= ONE_CHK) && ({1'b0, rsp.pos_y} <= ONE_CHK) &&
			({1'b0, rsp.pos_z} <= ONE_CHK)))
		else $error("surface point outside 0..1");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted item missing from first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.pos_x) &&
			$stable(rsp.pos_y) && $stable(rsp.pos_z))
		else $error("pipeline advanced during output stall");

endmodule

// File: rtl/rbsp_div.sv
// Pipelined restoring divider for three numerators over one shared weight sum.
// One quotient bit per stage with round-half-up offset; depends on rbsp_pkg.
module rbsp_div #(
	parameter int FRAC_BITS = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rbsp_pkg::rbsp_ctl_t    ctl,
	input  logic [FRAC_BITS+3:0]   num [3],
	input  logic [FRAC_BITS+3:0]   den,
	output logic                   valid,
	output logic [FRAC_BITS:0]     quot [3],
	output logic                   zero_den
);
	import rbsp_pkg::*;

	localparam int SW = FRAC_BITS + 4;
	localparam int DW = 2 * FRAC_BITS + 5;
	localparam int QW = FRAC_BITS + 1;
	localparam int NS = QW;

	logic [DW-1:0] rem_p [NS+1][3];
	logic [QW-1:0] q_p [NS+1][3];
	logic [SW-1:0] den_p [NS+1];
	logic          v_p [NS+1];

	// dividend = num * 2^F + den / 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p[0] <= 1'b0;
		end else if (ctl.ce) begin
			v_p[0] <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ce) begin
			den_p[0] <= den;
			for (int l = 0; l < 3; l++) begin
				rem_p[0][l] <= (DW'(num[l]) << FRAC_BITS) + DW'(den >> 1);
				q_p[0][l] <= '0;
			end
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		logic [DW-1:0] dsh;
		assign dsh = DW'(den_p[k]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else if (ctl.ce) begin
				v_p[k+1] <= v_p[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.ce) begin
				den_p[k+1] <= den_p[k];
				for (int l = 0; l < 3; l++) begin
					if (rem_p[k][l] >= dsh) begin
						rem_p[k+1][l] <= rem_p[k][l] - dsh;
						q_p[k+1][l] <= q_p[k][l] | (QW'(1) << SH);
					end else begin
						rem_p[k+1][l] <= rem_p[k][l];
						q_p[k+1][l] <= q_p[k][l];
					end
				end
			end
		end
	end

	assign valid = v_p[NS];
	assign quot = q_p[NS];
	assign zero_den = (den_p[NS] == '0);

endmodule
